/* hw/rtl/field_oriented_mecanum_mixer_defines.svh */
// Assertion macros shared by the mecanum mixer RTL.
// Each macro samples on clk_i and is disabled while rst_ni is low.
`ifndef FIELD_ORIENTED_MECANUM_MIXER_DEFINES_SVH
`define FIELD_ORIENTED_MECANUM_MIXER_DEFINES_SVH

// Checks a property on every rising clock edge outside of reset.
`define FOMM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that a condition implies another one in the next cycle.
`define FOMM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/fomm_pkg.sv */
// Package for the field oriented mecanum mixer.
// Holds datapath widths, pipeline depth and the CORDIC constants; no dependencies.
`timescale 1ns / 1ps

package fomm_pkg;

  // Datapath widths.
  localparam int unsigned CW   = 27;  // CORDIC x and y
  localparam int unsigned ZW   = 34;  // CORDIC angle accumulator
  localparam int unsigned SQW  = 34;  // square root radicand and remainder
  localparam int unsigned RTW  = 17;  // square root result
  localparam int unsigned WW   = 19;  // rotated vector and wheel sums
  localparam int unsigned PW   = 36;  // wheel magnitude times root
  localparam int unsigned DW   = 21;  // divisor, four times the maximum
  localparam int unsigned NW   = 38;  // dividend and remainder
  localparam int unsigned QW   = 18;  // quotient
  localparam int unsigned OW   = 18;  // output field width

  localparam int unsigned STEPS  = 16;  // CORDIC micro-rotations
  localparam int unsigned LANES  = 4;   // wheels
  localparam int unsigned NSTG   = 42;  // register stages from input to output

  // Wheel lanes.
  localparam int unsigned LF = 0;
  localparam int unsigned LR = 1;
  localparam int unsigned RF = 2;
  localparam int unsigned RR = 3;

  // 1/K of the CORDIC gain in Q0.16.
  localparam logic signed [17:0] INV_GAIN = 18'sd39797;

  // Scaling starts above 1.0 in Q.15.
  localparam logic signed [WW-1:0] UNITY = 19'sd32768;

  // Micro-rotation angles, 2^32 per turn.
  localparam logic [31:0] ATAN_TAB [STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C
  };

endpackage

/* hw/rtl/field_oriented_mecanum_mixer.sv */
// Field oriented mecanum mixer, fully pipelined top level.
// Depends on fomm_pkg and field_oriented_mecanum_mixer_defines.svh.
//
// Usage:
// The input channel carries one joystick sample per transaction: strafe,
// forward and turn in Q1.15 and a 16-bit binary heading. The output channel
// carries the four wheel commands of that sample in Q3.15, one transaction
// per input transaction, in order.
// A transaction is taken at a rising edge where valid is high and stall low.
// After the input register a sample passes these registered steps in order:
// pre-rotation, 16 CORDIC stages, gain, wheel mixing, the maximum, the
// products, the dividend, 18 restoring divide stages and the output register.
// A 17-step square root runs beside the CORDIC. Unless the pipeline is held,
// a new sample can enter every cycle: a sustained rate of one sample per cycle.
// The whole pipeline advances together; it holds only while a result waits
// in the output register and the receiver stalls, and then in_stall_o is high.
// Bubbles still move forward, so samples behind a gap keep advancing.
// Reset clears all valid bits; no result is presented until a sample passes.
`timescale 1ns / 1ps
`include "field_oriented_mecanum_mixer_defines.svh"

module field_oriented_mecanum_mixer
  import fomm_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic signed [15:0]    strafe_cmd_i,
  input  logic signed [15:0]    forward_cmd_i,
  input  logic signed [15:0]    turn_cmd_i,
  input  logic        [15:0]    heading_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic signed [OW-1:0]  left_front_drive_o,
  output logic signed [OW-1:0]  left_rear_drive_o,
  output logic signed [OW-1:0]  right_front_drive_o,
  output logic signed [OW-1:0]  right_rear_drive_o
);

  // Pipeline control.
  logic              en;
  logic [NSTG-1:0]   vld_q;

  // Input stage.
  logic signed [16:0] x0_q;
  logic signed [15:0] y0_q;
  logic signed [15:0] t0_q;
  logic        [15:0] h0_q;

  // CORDIC stages and carried turn command.
  logic signed [CW-1:0] cx_q [0:STEPS];
  logic signed [CW-1:0] cy_q [0:STEPS];
  logic signed [ZW-1:0] cz_q [0:STEPS];
  logic signed [CW-1:0] cx_d [0:STEPS];
  logic signed [CW-1:0] cy_d [0:STEPS];
  logic signed [ZW-1:0] cz_d [0:STEPS];
  logic signed [15:0]   tc_q [0:STEPS+1];

  // Squares and square root stages.
  logic [SQW-1:0] sqx_q, sqy_q;
  logic [SQW-1:0] sr_q [0:RTW];
  logic [RTW-1:0] rt_q [0:RTW];
  logic [SQW-1:0] sr_d [0:RTW];
  logic [RTW-1:0] rt_d [0:RTW];

  // Gain correction, wheels and maximum.
  logic signed [WW-1:0] xr_q, yr_q, xr_d, yr_d;
  logic signed [WW-1:0] w_q  [LANES];
  logic signed [WW-1:0] w2_q [LANES];
  logic signed [WW-1:0] m_q, m_d;
  logic [RTW-1:0]       hq2_q;

  // Products.
  logic [PW-1:0]        a_q  [LANES];
  logic                 ng_q [LANES];
  logic signed [WW-1:0] w3_q [LANES];
  logic [DW-1:0]        d3_q;
  logic                 sc3_q;

  // Divider stages.
  logic [NW-1:0]        dr_q [0:QW][LANES];
  logic [QW-1:0]        dq_q [0:QW][LANES];
  logic [NW-1:0]        dr_d [0:QW][LANES];
  logic [QW-1:0]        dq_d [0:QW][LANES];
  logic [DW-1:0]        dd_q [0:QW];
  logic                 ds_q [0:QW];
  logic                 dn_q [0:QW][LANES];
  logic signed [WW-1:0] dw_q [0:QW][LANES];

  // Output register.
  logic signed [OW-1:0] o_q [LANES];
  logic signed [OW-1:0] o_d [LANES];

  // Clamp a wheel value to the output range.
  function automatic logic signed [OW-1:0] sat_out(input logic signed [WW-1:0] v);
    logic signed [WW-1:0] hi;
    logic signed [WW-1:0] lo;
    hi = WW'(131071);
    lo = -WW'(131072);
    if (v > hi) begin
      sat_out = OW'(hi);
    end else if (v < lo) begin
      sat_out = OW'(lo);
    end else begin
      sat_out = OW'(v);
    end
  endfunction

  // The pipeline holds only when the output register is full and stalled.
  assign en         = !(vld_q[NSTG-1] && out_stall_i);
  assign in_stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NSTG-2:0], in_valid_i};
    end
  end

  // Pre-rotation into the right half plane and the CORDIC micro-rotations.
  always_comb begin
    logic [15:0] hr;
    logic        flip;
    flip = h0_q[15] ^ h0_q[14];
    hr   = flip ? (h0_q ^ 16'h8000) : h0_q;
    cx_d[0] = flip ? -(CW'(x0_q) <<< 8) : (CW'(x0_q) <<< 8);
    cy_d[0] = flip ? -(CW'(y0_q) <<< 8) : (CW'(y0_q) <<< 8);
    cz_d[0] = ZW'($signed(hr)) <<< 16;
    for (int k = 0; k < STEPS; k++) begin
      if (!cz_q[k][ZW-1]) begin
        cx_d[k+1] = cx_q[k] - (cy_q[k] >>> k);
        cy_d[k+1] = cy_q[k] + (cx_q[k] >>> k);
        cz_d[k+1] = cz_q[k] - $signed(ZW'(ATAN_TAB[k]));
      end else begin
        cx_d[k+1] = cx_q[k] + (cy_q[k] >>> k);
        cy_d[k+1] = cy_q[k] - (cx_q[k] >>> k);
        cz_d[k+1] = cz_q[k] + $signed(ZW'(ATAN_TAB[k]));
      end
    end
  end

  // Square root, one result bit per stage.
  always_comb begin
    logic [SQW-1:0] trial;
    sr_d[0] = (sqx_q + sqy_q) << 1;
    rt_d[0] = '0;
    trial   = '0;
    for (int j = 0; j < RTW; j++) begin
      trial = (SQW'(rt_q[j]) << (RTW - j)) + (SQW'(1) << (2 * (RTW - 1 - j)));
      if (sr_q[j] >= trial) begin
        sr_d[j+1] = sr_q[j] - trial;
        rt_d[j+1] = rt_q[j] | (RTW'(1) << (RTW - 1 - j));
      end else begin
        sr_d[j+1] = sr_q[j];
        rt_d[j+1] = rt_q[j];
      end
    end
  end

  // Gain correction with round half up.
  always_comb begin
    logic signed [CW+17:0] px;
    logic signed [CW+17:0] py;
    px   = cx_q[STEPS] * INV_GAIN;
    py   = cy_q[STEPS] * INV_GAIN;
    xr_d = WW'((px + ((CW+18)'(1) <<< 23)) >>> 24);
    yr_d = WW'((py + ((CW+18)'(1) <<< 23)) >>> 24);
  end

  // Largest signed wheel value through a two level compare tree.
  always_comb begin
    logic signed [WW-1:0] ma;
    logic signed [WW-1:0] mb;
    ma  = (w_q[LR] > w_q[LF]) ? w_q[LR] : w_q[LF];
    mb  = (w_q[RR] > w_q[RF]) ? w_q[RR] : w_q[RF];
    m_d = (mb > ma) ? mb : ma;
  end

  // Restoring division, one quotient bit per stage and lane.
  // The dividend 2a + 2m over the divisor 4m rounds to nearest, ties away.
  always_comb begin
    logic [NW-1:0] sh;
    sh = '0;
    for (int l = 0; l < LANES; l++) begin
      dr_d[0][l] = (NW'(a_q[l]) << 1) + (NW'(d3_q) >> 1);
      dq_d[0][l] = '0;
    end
    for (int j = 0; j < QW; j++) begin
      sh = NW'(dd_q[j]) << (QW - 1 - j);
      for (int l = 0; l < LANES; l++) begin
        if (dr_q[j][l] >= sh) begin
          dr_d[j+1][l] = dr_q[j][l] - sh;
          dq_d[j+1][l] = dq_q[j][l] | (QW'(1) << (QW - 1 - j));
        end else begin
          dr_d[j+1][l] = dr_q[j][l];
          dq_d[j+1][l] = dq_q[j][l];
        end
      end
    end
  end

  // Final select: scaled quotient with its sign, or the raw wheel value, clamped to the output range.
  always_comb begin
    logic signed [WW-1:0] qs;
    for (int l = 0; l < LANES; l++) begin
      qs = $signed(WW'(dq_q[QW][l]));
      if (dn_q[QW][l]) begin
        qs = -qs;
      end
      o_d[l] = sat_out(ds_q[QW] ? qs : dw_q[QW][l]);
    end
  end

  // Datapath registers; all advance together with the valid bits.
  always_ff @(posedge clk_i) begin
    if (en) begin
      x0_q <= -(17'(strafe_cmd_i));
      y0_q <= forward_cmd_i;
      t0_q <= turn_cmd_i;
      h0_q <= heading_i;

      sqx_q <= $unsigned(SQW'(x0_q) * SQW'(x0_q));
      sqy_q <= SQW'($unsigned(34'(y0_q) * 34'(y0_q)));
      tc_q[0] <= t0_q;
      for (int k = 0; k <= STEPS; k++) begin
        cx_q[k] <= cx_d[k];
        cy_q[k] <= cy_d[k];
        cz_q[k] <= cz_d[k];
        tc_q[k+1] <= tc_q[k];
      end
      for (int j = 0; j <= RTW; j++) begin
        sr_q[j] <= sr_d[j];
        rt_q[j] <= rt_d[j];
      end

      xr_q <= xr_d;
      yr_q <= yr_d;

      w_q[LF] <= yr_q + WW'(tc_q[STEPS+1]) + xr_q;
      w_q[LR] <= yr_q + WW'(tc_q[STEPS+1]) - xr_q;
      w_q[RF] <= -yr_q + WW'(tc_q[STEPS+1]) - xr_q;
      w_q[RR] <= -yr_q + WW'(tc_q[STEPS+1]) + xr_q;

      m_q   <= m_d;
      hq2_q <= rt_q[RTW];
      for (int l = 0; l < LANES; l++) begin
        w2_q[l] <= w_q[l];
        ng_q[l] <= w2_q[l][WW-1];
        a_q[l]  <= PW'($unsigned(w2_q[l][WW-1] ? WW'(-w2_q[l]) : WW'(w2_q[l])))
                   * PW'(hq2_q);
        w3_q[l] <= w2_q[l];
      end
      d3_q  <= DW'($unsigned(m_q)) << 2;
      sc3_q <= m_q > UNITY;

      dd_q[0] <= d3_q;
      ds_q[0] <= sc3_q;
      for (int l = 0; l < LANES; l++) begin
        dn_q[0][l] <= ng_q[l];
        dw_q[0][l] <= w3_q[l];
      end
      for (int j = 0; j <= QW; j++) begin
        for (int l = 0; l < LANES; l++) begin
          dr_q[j][l] <= dr_d[j][l];
          dq_q[j][l] <= dq_d[j][l];
        end
      end
      for (int j = 0; j < QW; j++) begin
        dd_q[j+1] <= dd_q[j];
        ds_q[j+1] <= ds_q[j];
        for (int l = 0; l < LANES; l++) begin
          dn_q[j+1][l] <= dn_q[j][l];
          dw_q[j+1][l] <= dw_q[j][l];
        end
      end

      for (int l = 0; l < LANES; l++) begin
        o_q[l] <= o_d[l];
      end
    end
  end

  assign out_valid_o         = vld_q[NSTG-1];
  assign left_front_drive_o  = o_q[LF];
  assign left_rear_drive_o   = o_q[LR];
  assign right_front_drive_o = o_q[RF];
  assign right_rear_drive_o  = o_q[RR];

  // A held pipeline must not move its valid bits.
  `FOMM_ASSERT_NEXT(a_hold_valid, !en, $stable(vld_q), "valid bits moved while held")
  // A stalled result must hold back the input side.
  `FOMM_ASSERT(a_stall_back, !(out_valid_o && out_stall_i) || in_stall_o, "input not stalled")
  // The root of a radicand up to 2^32 never exceeds 2^16.
  `FOMM_ASSERT(a_root_range, !vld_q[19] || (rt_q[RTW] <= RTW'(65536)), "square root too large")
  // With scaling active the quotient fit, so each remainder is below the divisor.
  `FOMM_ASSERT(a_div_rem, !(vld_q[NSTG-2] && ds_q[QW]) || ((dr_q[QW][LF] < NW'(dd_q[QW])) && (dr_q[QW][LR] < NW'(dd_q[QW])) && (dr_q[QW][RF] < NW'(dd_q[QW])) && (dr_q[QW][RR] < NW'(dd_q[QW]))), "quotient overflow")

endmodule

/* test/field_oriented_mecanum_mixer_checker.sv */
// Checker for the field oriented mecanum mixer: predicts wheel commands per sample.
// Watches both channels of u_top and counts mismatches; depends on fomm_pkg.
`timescale 1ns / 1ps

module field_oriented_mecanum_mixer_checker
  import fomm_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  logic signed [15:0]   strafe_cmd_i,
  input  logic signed [15:0]   forward_cmd_i,
  input  logic signed [15:0]   turn_cmd_i,
  input  logic        [15:0]   heading_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  logic signed [OW-1:0] left_front_drive_i,
  input  logic signed [OW-1:0] left_rear_drive_i,
  input  logic signed [OW-1:0] right_front_drive_i,
  input  logic signed [OW-1:0] right_rear_drive_i,
  output int                   errors_o,
  output int                   pending_o
);

  typedef struct packed {
    logic signed [OW-1:0] lf;
    logic signed [OW-1:0] lr;
    logic signed [OW-1:0] rf;
    logic signed [OW-1:0] rr;
  } wheels_t;

  wheels_t wheel_queue[$];

  // Angle table, 2^32 per turn.
  localparam longint ANGLE_STEP [16] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
    64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
    64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
    64'h00028BE6, 64'h000145F3, 64'h0000A2F9, 64'h0000517C
  };

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic longint scale_wheel(longint num, longint den);
    longint a;
    longint q;
    a = (num < 0) ? -num : num;
    q = (2 * a + den) / (2 * den);
    return (num < 0) ? -q : q;
  endfunction

  function automatic logic signed [OW-1:0] clamp18(longint v);
    if (v > 131071) v = 131071;
    if (v < -131072) v = -131072;
    return v[OW-1:0];
  endfunction

  // Rotate the stick vector by the heading, mix and normalize.
  function automatic wheels_t mix_wheels(logic signed [15:0] s, logic signed [15:0] f,
                                         logic signed [15:0] t, logic [15:0] hd);
    longint x0, y0, x, y, z, dx, dy, m, tt;
    longint w [4];
    longint unsigned hq;
    logic [15:0] h;
    wheels_t res;
    x0 = -longint'(s);
    y0 = longint'(f);
    tt = longint'(t);
    x = x0 * 256;
    y = y0 * 256;
    h = hd;
    if (hd >= 16384 && hd < 49152) begin
      x = -x;
      y = -y;
      h = hd - 16'd32768;
    end
    z = longint'($signed(h)) * 65536;
    for (int i = 0; i < 16; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= ANGLE_STEP[i];
      end else begin
        x += dx; y -= dy; z += ANGLE_STEP[i];
      end
    end
    x = (x * 39797 + (64'sd1 <<< 23)) >>> 24;
    y = (y * 39797 + (64'sd1 <<< 23)) >>> 24;
    hq = root_floor(longint'(2 * (x0 * x0 + y0 * y0)));
    w[0] = y + tt + x;
    w[1] = y + tt - x;
    w[2] = -y + tt - x;
    w[3] = -y + tt + x;
    m = w[0];
    for (int i = 1; i < 4; i++) if (w[i] > m) m = w[i];
    if (m > 32768)
      for (int i = 0; i < 4; i++) w[i] = scale_wheel(w[i] * longint'(hq), 2 * m);
    res.lf = clamp18(w[0]);
    res.lr = clamp18(w[1]);
    res.rf = clamp18(w[2]);
    res.rr = clamp18(w[3]);
    return res;
  endfunction

  assign pending_o = wheel_queue.size();

  // Predict on each accepted sample, compare on each accepted result.
  always @(posedge clk_i or negedge rst_ni) begin
    wheels_t want;
    wheels_t got;
    if (!rst_ni) begin
      errors_o <= 0;
    end else begin
      if (in_valid_i && !in_stall_i)
        wheel_queue.push_back(mix_wheels(strafe_cmd_i, forward_cmd_i, turn_cmd_i, heading_i));
      if (out_valid_i && !out_stall_i) begin
        got = '{left_front_drive_i, left_rear_drive_i, right_front_drive_i,
                right_rear_drive_i};
        if (wheel_queue.size() == 0) begin
          $display("%0t: unexpected transaction lf=%0d lr=%0d rf=%0d rr=%0d", $time,
                   got.lf, got.lr, got.rf, got.rr);
          errors_o <= errors_o + 1;
        end else begin
          want = wheel_queue.pop_front();
          if (want !== got) begin
            $display("%0t: expected lf=%0d lr=%0d rf=%0d rr=%0d, actual lf=%0d lr=%0d rf=%0d rr=%0d",
                     $time, want.lf, want.lr, want.rf, want.rr,
                     got.lf, got.lr, got.rf, got.rr);
            errors_o <= errors_o + 1;
          end
        end
      end
    end
  end

endmodule

/* test/field_oriented_mecanum_mixer_test.sv */
// Testbench top for the field oriented mecanum mixer: drives samples and stalls.
// Depends on fomm_pkg, the block and field_oriented_mecanum_mixer_checker.
`timescale 1ns / 1ps

module field_oriented_mecanum_mixer_test;
  import fomm_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic out_stall_i = 1'b0;
  logic signed [15:0] strafe_cmd_i = '0;
  logic signed [15:0] forward_cmd_i = '0;
  logic signed [15:0] turn_cmd_i = '0;
  logic [15:0] heading_i = '0;
  logic in_stall_o, out_valid_o;
  logic signed [OW-1:0] left_front_drive_o, left_rear_drive_o;
  logic signed [OW-1:0] right_front_drive_o, right_rear_drive_o;
  int errors, pending;
  int send_idle_pct = 37;
  int recv_idle_pct = 62;
  int hold_cycles = 0;
  logic hold_req = 1'b0;
  logic hold_done = 1'b0;

  field_oriented_mecanum_mixer u_top (.*);

  field_oriented_mecanum_mixer_checker u_check (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o),
    .strafe_cmd_i, .forward_cmd_i, .turn_cmd_i, .heading_i,
    .out_valid_i(out_valid_o), .out_stall_i,
    .left_front_drive_i(left_front_drive_o), .left_rear_drive_i(left_rear_drive_o),
    .right_front_drive_i(right_front_drive_o), .right_rear_drive_i(right_rear_drive_o),
    .errors_o(errors), .pending_o(pending)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Receiver stall: a long hold-off when requested, else random.
  always @(negedge clk_i) begin
    if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      out_stall_i <= 1'b1;
      hold_cycles <= 200;
    end else if (hold_cycles > 0) begin
      out_stall_i <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Offer one sample and wait until it is taken; random gaps before it.
  task automatic send_sample(logic [15:0] s, logic [15:0] f, logic [15:0] t,
                             logic [15:0] h);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    strafe_cmd_i <= s;
    forward_cmd_i <= f;
    turn_cmd_i <= t;
    heading_i <= h;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  function automatic logic [15:0] pick_axis();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'(signed'($urandom_range(512)) - 256);
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    logic [15:0] edge_vals [6] = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h4000, 16'hC000};
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    // Directed: extremes, zero stick, headings at quadrant borders.
    send_sample(16'h0000, 16'h0000, 16'h7FFF, 16'h1234);
    send_sample(16'h0000, 16'h0000, 16'h8000, 16'h0000);
    send_sample(16'h0000, 16'h8000, 16'h0000, 16'h0000);
    send_sample(16'h4000, 16'h4000, 16'h0000, 16'h0000);
    send_sample(16'hC000, 16'h4000, 16'h8000, 16'hFFFF);
    for (int i = 0; i < 6; i++)
      send_sample(edge_vals[i], edge_vals[5 - i], edge_vals[(i + 2) % 6],
                  {edge_vals[i][15:14], 14'h3FFF});
    send_sample(16'h8000, 16'h8000, 16'h7FFF, 16'h3FFF);
    send_sample(16'h7FFF, 16'h7FFF, 16'h8000, 16'hBFFF);
    send_sample(16'h8000, 16'h7FFF, 16'h8000, 16'h8000);
    send_sample(16'h0000, 16'h7FFF, 16'h0000, 16'h4000);
    send_sample(16'h0000, 16'h8000, 16'h8000, 16'hC000);
    // Random with three idling regimes.
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 37 : (phase == 1) ? 62 : 0;
      recv_idle_pct = (phase == 0) ? 62 : (phase == 1) ? 37 : 0;
      if (phase == 1) hold_req <= 1'b1;
      for (int n = 0; n < 660; n++)
        send_sample(pick_axis(), pick_axis(), pick_axis(), 16'($urandom));
      in_valid_i <= 1'b0;
      // Sender pauses until every result is back.
      wait (pending == 0);
      @(negedge clk_i);
    end
    repeat (60) @(negedge clk_i);
    if (errors == 0 && pending == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #20ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

/* field_oriented_mecanum_mixer.f */
+incdir+hw/rtl
hw/rtl/fomm_pkg.sv
hw/rtl/field_oriented_mecanum_mixer.sv
test/field_oriented_mecanum_mixer_checker.sv
test/field_oriented_mecanum_mixer_test.sv
